// File: sv/ray_reflect_refract_top_macros.svh
// Assertion helpers for the ray reflect/refract block.
`ifndef RAY_REFLECT_REFRACT_TOP_MACROS_SVH
`define RAY_REFLECT_REFRACT_TOP_MACROS_SVH

// Checked only while out of reset.
`define RRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RRR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/rrr_pkg.sv
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared widths and word types for the ray reflect/refract block.
// ----------------------------------------------------------------------------
package rrr_pkg;

  localparam int CW   = 16;          // component width
  localparam int FB   = CW - 2;      // fraction bits
  localparam int SW   = CW + 5;      // scalar (2d or cos) width
  localparam int RW   = CW + 3;      // square root remainder width
  localparam int PIPE = CW + 9;      // stages ahead of the output register

  typedef struct packed {
    logic                 op;
    logic signed [CW-1:0] in_x;
    logic signed [CW-1:0] in_y;
    logic signed [CW-1:0] in_z;
    logic signed [CW-1:0] norm_x;
    logic signed [CW-1:0] norm_y;
    logic signed [CW-1:0] norm_z;
    logic        [CW-1:0] eta_ratio;
  } rrr_in_t;

  typedef struct packed {
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic                 saturated;
  } rrr_out_t;

  typedef struct packed {
    logic signed [CW-1:0] refl;
    logic                 refl_clip;
    logic signed [CW-1:0] refr;
    logic                 refr_clip;
  } rrr_lane_res_t;

endpackage

// File: sv/ray_reflect_refract_top.sv
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, and in_ready is that same condition.
// The 16-stage square root pipeline sets the depth.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// ray_reflect_refract_top
// Reflect or refract a Q2.14 direction against a surface normal, three lanes.
// ----------------------------------------------------------------------------
module ray_reflect_refract_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrr_pkg::rrr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rrr_pkg::rrr_out_t out_data
);
  import rrr_pkg::*;

  localparam int DW = 2*CW + 2;

  logic                   adv;
  logic [PIPE-1:0]        vld_r;
  logic [PIPE-1:0]        op_r;
  logic signed [2*CW-1:0] prod [3];
  logic signed [2*CW-1:0] sq   [3];
  rrr_lane_res_t          res  [3];
  logic signed [CW-1:0]   vin  [3];
  logic signed [CW-1:0]   nin  [3];
  logic signed [SW-1:0]   sc_nxt, sc_r;
  logic signed [DW-1:0]   dsum, nsum, dfl, cfl, one_w;
  logic [DW-1:0]          lsum, len2;
  logic signed [DW:0]     kdiff;
  logic [DW:0]            kabs;
  logic [2*CW-1:0]        rad_nxt, rad_r;
  logic [CW-1:0]          root;
  logic                   out_valid_r;
  rrr_out_t               out_data_r, out_data_nxt;

  // advance everything when the output register can take a word
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign vin[0] = in_data.in_x;
  assign vin[1] = in_data.in_y;
  assign vin[2] = in_data.in_z;
  assign nin[0] = in_data.norm_x;
  assign nin[1] = in_data.norm_y;
  assign nin[2] = in_data.norm_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rrr_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .v_i    (vin[i]),
      .n_i    (nin[i]),
      .eta_i  (in_data.eta_ratio),
      .sc_i   (sc_r),
      .root_i (root),
      .prod_o (prod[i]),
      .sq_o   (sq[i]),
      .res_o  (res[i])
    );
  end

  // merge dot products: 2*floor(v.n) for reflect, min(floor(-v.n), one) for refract
  assign one_w  = DW'(1) <<< FB;
  assign dsum   = DW'(prod[0]) + DW'(prod[1]) + DW'(prod[2]);
  assign nsum   = -dsum;
  assign dfl    = dsum >>> FB;
  assign cfl    = nsum >>> FB;
  assign sc_nxt = op_r[0] ? ((cfl > one_w) ? SW'(one_w) : SW'(cfl))
                          : (SW'(dfl) <<< 1);

  // merge squared perp: k = |one - floor(perp.perp)|, radicand k * 2^FB
  assign lsum    = DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]);
  assign len2    = lsum >> FB;
  assign kdiff   = $signed({1'b0, one_w}) - $signed({1'b0, len2});
  assign kabs    = kdiff[DW] ? (DW+1)'(0) - kdiff : kdiff;
  assign rad_nxt = (2*CW)'(kabs << FB);

  rrr_isqrt u_isqrt (
    .clk    (clk),
    .adv    (adv),
    .rad_i  (rad_r),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_r  <= sc_nxt;
      rad_r <= rad_nxt;
      op_r  <= {op_r[PIPE-2:0], in_data.op};
    end
  end

  // final select by op and fold the clip flags
  always_comb begin
    if (op_r[PIPE-1]) begin
      out_data_nxt.out_x     = res[0].refr;
      out_data_nxt.out_y     = res[1].refr;
      out_data_nxt.out_z     = res[2].refr;
      out_data_nxt.saturated = res[0].refr_clip | res[1].refr_clip | res[2].refr_clip;
    end else begin
      out_data_nxt.out_x     = res[0].refl;
      out_data_nxt.out_y     = res[1].refl;
      out_data_nxt.out_z     = res[2].refl;
      out_data_nxt.saturated = res[0].refl_clip | res[1].refl_clip | res[2].refl_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE-2:0], in_valid};
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/rrr_isqrt.sv
// ----------------------------------------------------------------------------
// rrr_isqrt
// Pipelined integer square root, rounded down, one root bit per stage.
// ----------------------------------------------------------------------------
module rrr_isqrt (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [2*rrr_pkg::CW-1:0]    rad_i,
  output logic [rrr_pkg::CW-1:0]      root_o
);
  import rrr_pkg::*;

  logic [2*CW-1:0] rad_r  [1:CW];
  logic [RW-1:0]   rem_r  [1:CW];
  logic [CW-1:0]   root_r [1:CW];

  for (genvar g = 0; g < CW; g++) begin : g_stage
    logic [2*CW-1:0] rad_src;
    logic [RW-1:0]   rem_src;
    logic [CW-1:0]   root_src;
    logic [RW-1:0]   remsh;
    logic [RW-1:0]   trial;
    logic            take;

    if (g == 0) begin : g_first
      assign rad_src  = rad_i;
      assign rem_src  = '0;
      assign root_src = '0;
    end else begin : g_next
      assign rad_src  = rad_r[g];
      assign rem_src  = rem_r[g];
      assign root_src = root_r[g];
    end

    assign remsh = {rem_src[RW-3:0], rad_src[2*CW-1 -: 2]};
    assign trial = RW'({root_src, 2'b01});
    assign take  = (remsh >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[g+1]  <= rad_src << 2;
        rem_r[g+1]  <= take ? (remsh - trial) : remsh;
        root_r[g+1] <= {root_src[CW-2:0], take};
      end
    end
  end

  assign root_o = root_r[CW];

endmodule

// File: sv/rrr_lane.sv
// ----------------------------------------------------------------------------
// rrr_lane
// Per-component datapath: products, reflect result, perp, final refract sum.
// ----------------------------------------------------------------------------
module rrr_lane (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [rrr_pkg::CW-1:0]     v_i,
  input  logic signed [rrr_pkg::CW-1:0]     n_i,
  input  logic        [rrr_pkg::CW-1:0]     eta_i,
  input  logic signed [rrr_pkg::SW-1:0]     sc_i,
  input  logic        [rrr_pkg::CW-1:0]     root_i,
  output logic signed [2*rrr_pkg::CW-1:0]   prod_o,
  output logic signed [2*rrr_pkg::CW-1:0]   sq_o,
  output rrr_pkg::rrr_lane_res_t            res_o
);
  import rrr_pkg::*;

  localparam int TW  = CW + 6;
  localparam int MW  = TW + CW + 1;
  localparam int XW  = MW + 1;
  localparam int QW  = SW + CW;
  localparam int DLY = CW + 2;

  typedef struct packed {
    logic [CW:0]          perp;   // clip flag over value
    logic [CW:0]          refl;
    logic signed [CW-1:0] n;
  } lane_carry_t;

  function automatic logic [CW:0] sat(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = ~hi;
    if (x > hi)      sat = {1'b1, hi[CW-1:0]};
    else if (x < lo) sat = {1'b1, lo[CW-1:0]};
    else             sat = {1'b0, x[CW-1:0]};
  endfunction

  logic signed [CW-1:0]   v1_r, v2_r, v3_r;
  logic signed [CW-1:0]   n1_r, n2_r, n3_r, n4_r, n5_r, n6_r;
  logic        [CW-1:0]   eta1_r, eta2_r, eta3_r, eta4_r;
  logic signed [2*CW-1:0] p1_r;
  logic signed [QW-1:0]   q3_nxt, q3_r;
  logic signed [TW-1:0]   qsh, t4_nxt, r4w, t4_r;
  logic [CW:0]            refl4_r, refl5_r, refl6_r;
  logic signed [MW-1:0]   m5_nxt, m5_r;
  logic [CW:0]            perp6_r;
  logic signed [CW-1:0]   perp6v;
  logic signed [2*CW-1:0] sq7_nxt, sq7_r;
  lane_carry_t            dly_r [0:DLY-1];
  logic signed [2*CW:0]   qf_nxt, qf_r;
  lane_carry_t            cf_r;
  logic signed [2*CW+1:0] negq;
  logic signed [XW-1:0]   fsum;
  logic [CW:0]            refr;

  assign q3_nxt = sc_i * n2_r;
  assign qsh    = TW'(q3_r >>> FB);
  assign t4_nxt = TW'(v3_r) + qsh;
  assign r4w    = TW'(v3_r) - qsh;
  assign m5_nxt = t4_r * $signed({1'b0, eta4_r});
  assign perp6v = perp6_r[CW-1:0];
  assign sq7_nxt = perp6v * perp6v;
  assign qf_nxt = $signed({1'b0, root_i}) * dly_r[DLY-1].n;

  always_ff @(posedge clk) begin
    if (adv) begin
      v1_r    <= v_i;
      n1_r    <= n_i;
      eta1_r  <= eta_i;
      p1_r    <= v_i * n_i;
      v2_r    <= v1_r;
      n2_r    <= n1_r;
      eta2_r  <= eta1_r;
      q3_r    <= q3_nxt;
      v3_r    <= v2_r;
      n3_r    <= n2_r;
      eta3_r  <= eta2_r;
      t4_r    <= t4_nxt;
      refl4_r <= sat(XW'(r4w));
      n4_r    <= n3_r;
      eta4_r  <= eta3_r;
      m5_r    <= m5_nxt;
      refl5_r <= refl4_r;
      n5_r    <= n4_r;
      perp6_r <= sat(XW'(m5_r >>> FB));
      refl6_r <= refl5_r;
      n6_r    <= n5_r;
      sq7_r   <= sq7_nxt;
      dly_r[0] <= '{perp: perp6_r, refl: refl6_r, n: n6_r};
      for (int j = 1; j < DLY; j++) begin
        dly_r[j] <= dly_r[j-1];
      end
      qf_r <= qf_nxt;
      cf_r <= dly_r[DLY-1];
    end
  end

  // floor(-s*n) then add to perp
  assign negq = -((2*CW+2)'(qf_r));
  assign fsum = XW'($signed(cf_r.perp[CW-1:0])) + XW'(negq >>> FB);
  assign refr = sat(fsum);

  assign prod_o          = p1_r;
  assign sq_o            = sq7_r;
  assign res_o.refl      = cf_r.refl[CW-1:0];
  assign res_o.refl_clip = cf_r.refl[CW];
  assign res_o.refr      = refr[CW-1:0];
  assign res_o.refr_clip = refr[CW] | cf_r.perp[CW];

endmodule

// File: sv/rrr_chk.sv
// ----------------------------------------------------------------------------
// rrr_chk
// Port-level checks for the ray reflect/refract block, bound to the top.
// ----------------------------------------------------------------------------
`include "ray_reflect_refract_top_macros.svh"

module rrr_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input rrr_pkg::rrr_out_t out_data
);

  `RRR_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "output word valid after reset")
  `RRR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled output word changed")
  `RRR_ASSERT(a_stall_blocks, out_valid && !out_ready |-> !in_ready, "input taken while output stalled")
  `RRR_ASSERT(a_empty_ready, !out_valid |-> in_ready, "not ready with empty output register")

endmodule

bind ray_reflect_refract_top rrr_chk u_rrr_chk (.*);

// File: test/tb_ray_reflect_refract_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray reflect/refract testbench
// Drives directed and random words through the reflect/refract pipeline and
// compares each output word to a hand value or a fixed-point predictor, with
// random gaps on both sides, one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_ray_reflect_refract_top;
  import rrr_pkg::*;

  localparam int    N_RANDOM   = 1500;
  localparam int    STALL_LIM  = 20000;
  localparam int    DRAIN_WAIT = 60;
  localparam int    HOLD_LEN   = 200;
  localparam logic  OP_REFLECT = 1'b0;
  localparam logic  OP_REFRACT = 1'b1;
  localparam longint ONE       = 64'sd1 << FB;
  localparam longint CMAX      = (64'sd1 << (CW - 1)) - 1;
  localparam longint CMIN      = -(64'sd1 << (CW - 1));

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rrr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rrr_out_t out_data;

  rrr_out_t expected_dirs[$];
  int       err_cnt = 0;
  int       idle_cycles = 0;
  bit       stim_done = 0;
  bit       hold_req = 0;
  bit       hold_done = 0;

  ray_reflect_refract_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor of x / 2^FB; >>> on signed longint is an arithmetic shift.
  function automatic longint fshr(longint x);
    return x >>> FB;
  endfunction

  function automatic longint clip(longint v, ref bit sat);
    if (v > CMAX) begin
      sat = 1;
      return CMAX;
    end
    if (v < CMIN) begin
      sat = 1;
      return CMIN;
    end
    return v;
  endfunction

  function automatic longint isqrt(longint x);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= x) r += 64'sd1 << b;
    end
    return r;
  endfunction

  // Bounce or bend one direction against the normal.
  function automatic rrr_out_t bounce_or_bend(rrr_in_t w);
    longint v[3], n[3], r[3], p[3], d2, c, len2, k, s;
    bit sat;
    rrr_out_t o;
    sat = 0;
    v[0] = longint'(w.in_x);   v[1] = longint'(w.in_y);   v[2] = longint'(w.in_z);
    n[0] = longint'(w.norm_x); n[1] = longint'(w.norm_y); n[2] = longint'(w.norm_z);
    if (w.op == OP_REFLECT) begin
      d2 = 2 * fshr(v[0] * n[0] + v[1] * n[1] + v[2] * n[2]);
      for (int i = 0; i < 3; i++) r[i] = clip(v[i] - fshr(d2 * n[i]), sat);
    end else begin
      c = fshr(-(v[0] * n[0] + v[1] * n[1] + v[2] * n[2]));
      if (c > ONE) c = ONE;
      for (int i = 0; i < 3; i++)
        p[i] = clip(fshr((v[i] + fshr(c * n[i])) * longint'(w.eta_ratio)), sat);
      len2 = fshr(p[0] * p[0] + p[1] * p[1] + p[2] * p[2]);
      k = ONE - len2;
      if (k < 0) k = -k;
      s = isqrt(k << FB);
      for (int i = 0; i < 3; i++) r[i] = clip(p[i] + fshr(-s * n[i]), sat);
    end
    o.out_x = r[0][CW-1:0];
    o.out_y = r[1][CW-1:0];
    o.out_z = r[2][CW-1:0];
    o.saturated = sat;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return $urandom_range(0, 1) ? CW'(ONE) : CW'(-ONE);
      default: return CW'($urandom_range(0, 2 ** CW - 1));
    endcase
  endfunction

  // Mostly unit-ish vectors with random content so refraction stays near
  // the physical regime; the rest is full-range noise.
  function automatic rrr_in_t rand_word();
    rrr_in_t w;
    w.op = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) != 0) begin
      w.in_x   = CW'(longint'($urandom_range(0, 32'(2 * ONE))) - ONE);
      w.in_y   = CW'(longint'($urandom_range(0, 32'(2 * ONE))) - ONE);
      w.in_z   = CW'(longint'($urandom_range(0, 32'(2 * ONE))) - ONE);
      w.norm_x = CW'(longint'($urandom_range(0, 32'(2 * ONE))) - ONE);
      w.norm_y = CW'(longint'($urandom_range(0, 32'(2 * ONE))) - ONE);
      w.norm_z = CW'(longint'($urandom_range(0, 32'(2 * ONE))) - ONE);
      w.eta_ratio = CW'($urandom_range(32'(ONE / 2), 32'(2 * ONE)));
    end else begin
      w.in_x = rand_comp();   w.in_y = rand_comp();   w.in_z = rand_comp();
      w.norm_x = rand_comp(); w.norm_y = rand_comp(); w.norm_z = rand_comp();
      w.eta_ratio = CW'($urandom_range(0, 2 ** CW - 1));
    end
    return w;
  endfunction

  // Directed rows. has_want marks rows whose answer is read off by hand.
  typedef struct {
    rrr_in_t  w;
    bit       has_want;
    rrr_out_t want;
  } row_t;
  row_t rows[$];

  function automatic rrr_in_t mk(logic op, int x, int y, int z, int nx, int ny, int nz,
                                 int eta);
    rrr_in_t w;
    w.op = op;
    w.in_x = CW'(x); w.in_y = CW'(y); w.in_z = CW'(z);
    w.norm_x = CW'(nx); w.norm_y = CW'(ny); w.norm_z = CW'(nz);
    w.eta_ratio = CW'(eta);
    return w;
  endfunction

  function automatic rrr_out_t mo(int x, int y, int z, bit s);
    rrr_out_t o;
    o.out_x = CW'(x); o.out_y = CW'(y); o.out_z = CW'(z); o.saturated = s;
    return o;
  endfunction

  initial begin
    // Zero vectors reflect to zero.
    rows.push_back('{mk(OP_REFLECT, 0, 0, 0, 0, 0, 0, 0), 1'b1, mo(0, 0, 0, 1'b0)});
    // Head-on reflection off a unit normal: -z bounces back to +z.
    rows.push_back('{mk(OP_REFLECT, 0, 0, -16384, 0, 0, 16384, 0), 1'b1,
                     mo(0, 0, 16384, 1'b0)});
    // Grazing ray: no component along the normal, passes unchanged.
    rows.push_back('{mk(OP_REFLECT, 16384, 0, 0, 0, 0, 16384, 0), 1'b1,
                     mo(16384, 0, 0, 1'b0)});
    // Zero normal: reflect returns the input, extremes included.
    rows.push_back('{mk(OP_REFLECT, -32768, 32767, -1, 0, 0, 0, 0), 1'b1,
                     mo(-32768, 32767, -1, 1'b0)});
    // Head-on refraction with eta one: passes straight through.
    rows.push_back('{mk(OP_REFRACT, 0, 0, -16384, 0, 0, 16384, 16384), 1'b1,
                     mo(0, 0, -16384, 1'b0)});
    // Refract with zero normal and zero eta: everything collapses to zero.
    rows.push_back('{mk(OP_REFRACT, 12345, -32768, 32767, 0, 0, 0, 0), 1'b1,
                     mo(0, 0, 0, 1'b0)});
    // Extremes that saturate; predictor checked.
    rows.push_back('{mk(OP_REFLECT, 32767, 32767, 32767, 32767, 32767, 32767, 0), 1'b0, '0});
    rows.push_back('{mk(OP_REFLECT, -32768, -32768, -32768, -32768, -32768, -32768, 0),
                     1'b0, '0});
    rows.push_back('{mk(OP_REFLECT, -32768, 32767, -32768, 32767, -32768, 32767, 65535),
                     1'b0, '0});
    rows.push_back('{mk(OP_REFRACT, 32767, 32767, 32767, 32767, 32767, 32767, 65535),
                     1'b0, '0});
    rows.push_back('{mk(OP_REFRACT, -32768, -32768, -32768, -32768, -32768, -32768, 65535),
                     1'b0, '0});
    rows.push_back('{mk(OP_REFRACT, -32768, 32767, -1, 1, -1, 32767, 65535), 1'b0, '0});
    // Cos clamped to one, total internal reflection (|perp| > 1).
    rows.push_back('{mk(OP_REFRACT, -23170, 0, -23170, 0, 0, 32767, 32767), 1'b0, '0});
    rows.push_back('{mk(OP_REFRACT, 16384, 0, -100, 0, 0, 16384, 40000), 1'b0, '0});
    // Oblique refraction, normal-sized inputs; then tiny inputs, both ops.
    rows.push_back('{mk(OP_REFRACT, 11585, 0, -11585, 0, 0, 16384, 10923), 1'b0, '0});
    rows.push_back('{mk(OP_REFRACT, 11585, 0, -11585, 0, 0, 16384, 24576), 1'b0, '0});
    rows.push_back('{mk(OP_REFLECT, 1, -1, 1, -1, 1, -1, 1), 1'b0, '0});
    rows.push_back('{mk(OP_REFRACT, 1, -1, 1, -1, 1, -1, 1), 1'b0, '0});
  end

  // Sender: directed table, then random words, with a drain pause midway.
  initial begin
    int   gap;
    bit   drain;
    rrr_in_t w;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < rows.size() + N_RANDOM; i++) begin
      drain = (i == rows.size() + N_RANDOM / 2);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
          : (i % 300 < 150) ? 0 : $urandom_range(0, 2);
      // Drop valid only when the next word does not follow at once.
      if (drain || gap != 0) in_valid <= 1'b0;
      if (drain) begin
        // Pause until the pipe drains completely.
        while (expected_dirs.size() != 0) @(posedge clk);
      end
      if (i == rows.size() + N_RANDOM / 4) hold_req <= 1'b1;
      repeat (gap) @(posedge clk);
      w = (i < rows.size()) ? rows[i].w : rand_word();
      in_valid <= 1'b1;
      in_data  <= w;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      // Accepted on this edge; log the expectation.
      if (i < rows.size() && rows[i].has_want) begin
        if (bounce_or_bend(w) != rows[i].want)
          $display("note: row %0d hand value differs from predictor", i);
        expected_dirs.push_back(rows[i].want);
      end else begin
        expected_dirs.push_back(bounce_or_bend(w));
      end
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stalls, plus one long hold-off while the sender runs.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_done = 1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      stall = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
            : ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each taken output word to the oldest expectation.
  always @(posedge clk) begin
    rrr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_dirs.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_dirs.pop_front();
        if (out_data.out_x !== want.out_x) report_mismatch("out_x", out_data.out_x, want.out_x);
        if (out_data.out_y !== want.out_y) report_mismatch("out_y", out_data.out_y, want.out_y);
        if (out_data.out_z !== want.out_z) report_mismatch("out_z", out_data.out_z, want.out_z);
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", out_data.saturated, want.saturated);
      end
    end
  end

  // Watchdog: count edges with no word moving on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIM) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // End: wait out the last expectation, then settle and report.
  initial begin
    wait (stim_done);
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0 && expected_dirs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/rrr_pkg.sv
sv/rrr_isqrt.sv
sv/rrr_lane.sv
sv/ray_reflect_refract_top.sv
sv/rrr_chk.sv
test/tb_ray_reflect_refract_top.sv
